// ===== src/cau_pkg.sv =====
package cau_pkg;

  // part width and fraction bits of the operand and result words
  localparam int PART_W = 32;
  localparam int FRAC_W = 16;

  // derived widths
  localparam int PROD_W = 2 * PART_W;          // exact product of two parts
  localparam int SUM_W  = PROD_W + 1;          // sum of two products
  localparam int DEN_W  = PROD_W;              // squared magnitude of the divisor
  localparam int QUO_W  = PART_W + 1;          // quotient bits kept, before halving
  localparam int MAG_W  = SUM_W + 1;           // common width for clamping

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_REM = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_DIV_ZERO = 2'd2,
    ST_SAT      = 2'd3
  } st_e;

  typedef struct packed {
    logic [2:0]               operation;
    logic signed [PART_W-1:0] a_real;
    logic signed [PART_W-1:0] a_imag;
    logic signed [PART_W-1:0] b_real;
    logic signed [PART_W-1:0] b_imag;
  } in_word_t;

  typedef struct packed {
    logic signed [PART_W-1:0] result_real;
    logic signed [PART_W-1:0] result_imag;
    logic [1:0]               status;
  } out_word_t;

  // products after the multiplier stage
  typedef struct packed {
    logic [2:0]               op;
    logic signed [PART_W:0]   sum_re;
    logic signed [PART_W:0]   sum_im;
    logic signed [PROD_W-1:0] p_rr;
    logic signed [PROD_W-1:0] p_ii;
    logic signed [PROD_W-1:0] p_ri;
    logic signed [PROD_W-1:0] p_ir;
    logic signed [PROD_W-1:0] p_bbr;
    logic signed [PROD_W-1:0] p_bbi;
  } prod_t;

  // one part of the result as it moves through the divider
  typedef struct packed {
    logic              neg;
    logic [SUM_W-1:0]  mag;
    logic [QUO_W-1:0]  quo;
    logic              ovf;
    logic [DEN_W-1:0]  rem;
  } lane_t;

  typedef struct packed {
    logic [2:0]             op;
    logic signed [PART_W:0] sum_re;
    logic signed [PART_W:0] sum_im;
    logic [DEN_W-1:0]       den;
    lane_t                  re;
    lane_t                  im;
  } dvs_t;

  typedef struct packed {
    logic signed [PART_W-1:0] val;
    logic                     sat;
  } part_t;

  // clamp a sign and magnitude to the part range
  function automatic part_t clamp_mag(logic neg, logic [MAG_W-1:0] mag);
    part_t             r;
    logic [MAG_W-1:0]  lim;
    logic [MAG_W-1:0]  m;
    lim   = {{(MAG_W-PART_W){1'b0}}, neg, {(PART_W-1){~neg}}};
    r.sat = mag > lim;
    m     = r.sat ? lim : mag;
    r.val = neg ? -m[PART_W-1:0] : m[PART_W-1:0];
    return r;
  endfunction

endpackage

// ===== src/cau_front.sv =====
module cau_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cau_pkg::in_word_t in_word_i,
  output logic              dn_valid_o,
  input  logic              dn_ready_i,
  output cau_pkg::dvs_t     dn_data_o
);
  import cau_pkg::*;

  prod_t s1_d, s1_q;
  dvs_t  s2_d, s2_q;
  dvs_t  s3_d, s3_q;
  logic  s1_valid_q, s2_valid_q, s3_valid_q;
  logic  s1_ready, s2_ready, s3_ready;

  logic signed [SUM_W-1:0] num_re, num_im;
  logic [SUM_W-1:0]        hi_re, hi_im, den_ext;

  // stage 1: add/sub and the six products
  always_comb begin
    s1_d.op     = in_word_i.operation;
    s1_d.sum_re = (in_word_i.operation == OP_SUB)
                ? PART_W'(0) + {in_word_i.a_real[PART_W-1], in_word_i.a_real}
                  - {in_word_i.b_real[PART_W-1], in_word_i.b_real}
                : {in_word_i.a_real[PART_W-1], in_word_i.a_real}
                  + {in_word_i.b_real[PART_W-1], in_word_i.b_real};
    s1_d.sum_im = (in_word_i.operation == OP_SUB)
                ? {in_word_i.a_imag[PART_W-1], in_word_i.a_imag}
                  - {in_word_i.b_imag[PART_W-1], in_word_i.b_imag}
                : {in_word_i.a_imag[PART_W-1], in_word_i.a_imag}
                  + {in_word_i.b_imag[PART_W-1], in_word_i.b_imag};
    s1_d.p_rr   = PROD_W'(in_word_i.a_real) * PROD_W'(in_word_i.b_real);
    s1_d.p_ii   = PROD_W'(in_word_i.a_imag) * PROD_W'(in_word_i.b_imag);
    s1_d.p_ri   = PROD_W'(in_word_i.a_real) * PROD_W'(in_word_i.b_imag);
    s1_d.p_ir   = PROD_W'(in_word_i.a_imag) * PROD_W'(in_word_i.b_real);
    s1_d.p_bbr  = PROD_W'(in_word_i.b_real) * PROD_W'(in_word_i.b_real);
    s1_d.p_bbi  = PROD_W'(in_word_i.b_imag) * PROD_W'(in_word_i.b_imag);
  end

  // stage 2: combine products, split into sign and magnitude
  always_comb begin
    if (s1_q.op == OP_DIV) begin
      num_re = SUM_W'(s1_q.p_rr) + SUM_W'(s1_q.p_ii);
      num_im = SUM_W'(s1_q.p_ir) - SUM_W'(s1_q.p_ri);
    end else begin
      num_re = SUM_W'(s1_q.p_rr) - SUM_W'(s1_q.p_ii);
      num_im = SUM_W'(s1_q.p_ri) + SUM_W'(s1_q.p_ir);
    end
    s2_d.op     = s1_q.op;
    s2_d.sum_re = s1_q.sum_re;
    s2_d.sum_im = s1_q.sum_im;
    s2_d.den    = DEN_W'(s1_q.p_bbr) + DEN_W'(s1_q.p_bbi);
    s2_d.re.neg = num_re[SUM_W-1];
    s2_d.re.mag = num_re[SUM_W-1] ? SUM_W'(-num_re) : SUM_W'(num_re);
    s2_d.re.quo = '0;
    s2_d.re.ovf = 1'b0;
    s2_d.re.rem = '0;
    s2_d.im.neg = num_im[SUM_W-1];
    s2_d.im.mag = num_im[SUM_W-1] ? SUM_W'(-num_im) : SUM_W'(num_im);
    s2_d.im.quo = '0;
    s2_d.im.ovf = 1'b0;
    s2_d.im.rem = '0;
  end

  // stage 3: quotient overflow check and initial partial remainder
  always_comb begin
    hi_re   = s2_q.re.mag >> (PART_W - FRAC_W);
    hi_im   = s2_q.im.mag >> (PART_W - FRAC_W);
    den_ext = SUM_W'(s2_q.den);
    s3_d        = s2_q;
    s3_d.re.ovf = hi_re >= den_ext;
    s3_d.re.rem = hi_re[DEN_W-1:0];
    s3_d.im.ovf = hi_im >= den_ext;
    s3_d.im.rem = hi_im[DEN_W-1:0];
  end

  // stage handshakes
  assign s3_ready   = !s3_valid_q || dn_ready_i;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= in_valid_i;
      if (s2_ready) s2_valid_q <= s1_valid_q;
      if (s3_ready) s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) s1_q <= s1_d;
    if (s2_ready && s1_valid_q) s2_q <= s2_d;
    if (s3_ready && s2_valid_q) s3_q <= s3_d;
  end

  assign dn_valid_o = s3_valid_q;
  assign dn_data_o  = s3_q;

endmodule

// ===== src/cau_div_step.sv =====
module cau_div_step #(
  parameter int BitPos = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          up_valid_i,
  output logic          up_ready_o,
  input  cau_pkg::dvs_t up_data_i,
  output logic          dn_valid_o,
  input  logic          dn_ready_i,
  output cau_pkg::dvs_t dn_data_o
);
  import cau_pkg::*;

  localparam int SrcBit = BitPos - FRAC_W - 1;

  dvs_t data_d, data_q;
  logic valid_q;
  logic xbit_re, xbit_im;
  logic [DEN_W:0] r2_re, r2_im, den_x;

  // next dividend bit: magnitude shifted up by fraction bits plus one
  if (SrcBit >= 0) begin : g_src
    assign xbit_re = up_data_i.re.mag[SrcBit];
    assign xbit_im = up_data_i.im.mag[SrcBit];
  end else begin : g_zero
    assign xbit_re = 1'b0;
    assign xbit_im = 1'b0;
  end

  // one restoring division step per part
  always_comb begin
    den_x  = {1'b0, up_data_i.den};
    r2_re  = {up_data_i.re.rem, xbit_re};
    r2_im  = {up_data_i.im.rem, xbit_im};
    data_d = up_data_i;
    if (r2_re >= den_x) begin
      data_d.re.rem         = DEN_W'(r2_re - den_x);
      data_d.re.quo[BitPos] = 1'b1;
    end else begin
      data_d.re.rem = r2_re[DEN_W-1:0];
    end
    if (r2_im >= den_x) begin
      data_d.im.rem         = DEN_W'(r2_im - den_x);
      data_d.im.quo[BitPos] = 1'b1;
    end else begin
      data_d.im.rem = r2_im[DEN_W-1:0];
    end
  end

  assign up_ready_o = !valid_q || dn_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready_o && up_valid_i) data_q <= data_d;
  end

  assign dn_valid_o = valid_q;
  assign dn_data_o  = data_q;

endmodule

// ===== src/cau_back.sv =====
module cau_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               up_valid_i,
  output logic               up_ready_o,
  input  cau_pkg::dvs_t      up_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cau_pkg::out_word_t out_word_o
);
  import cau_pkg::*;

  localparam logic [MAG_W-1:0] RoundHalf = (MAG_W'(1) << FRAC_W) >> 1;

  out_word_t        word_d, word_q;
  logic             valid_q;
  part_t            p_re, p_im;
  logic [MAG_W-1:0] add_re, add_im;
  logic [MAG_W-1:0] mul_re, mul_im;
  logic [MAG_W-1:0] div_re, div_im;
  logic [PART_W:0]  abs_re, abs_im;

  // magnitudes for each operation
  always_comb begin
    abs_re = up_data_i.sum_re[PART_W] ? -up_data_i.sum_re : up_data_i.sum_re;
    abs_im = up_data_i.sum_im[PART_W] ? -up_data_i.sum_im : up_data_i.sum_im;
    add_re = MAG_W'(abs_re);
    add_im = MAG_W'(abs_im);
    mul_re = (MAG_W'(up_data_i.re.mag) + RoundHalf) >> FRAC_W;
    mul_im = (MAG_W'(up_data_i.im.mag) + RoundHalf) >> FRAC_W;
    div_re = (MAG_W'(up_data_i.re.quo) + MAG_W'(1)) >> 1;
    div_im = (MAG_W'(up_data_i.im.quo) + MAG_W'(1)) >> 1;
  end

  // select, round and clamp
  always_comb begin
    p_re   = '0;
    p_im   = '0;
    word_d = '0;
    unique case (up_data_i.op)
      OP_ADD, OP_SUB: begin
        p_re = clamp_mag(up_data_i.sum_re[PART_W], add_re);
        p_im = clamp_mag(up_data_i.sum_im[PART_W], add_im);
        word_d.status = (p_re.sat || p_im.sat) ? ST_SAT : ST_OK;
      end
      OP_MUL: begin
        p_re = clamp_mag(up_data_i.re.neg, mul_re);
        p_im = clamp_mag(up_data_i.im.neg, mul_im);
        word_d.status = (p_re.sat || p_im.sat) ? ST_SAT : ST_OK;
      end
      OP_DIV: begin
        if (up_data_i.den == '0) begin
          word_d.status = ST_DIV_ZERO;
        end else begin
          p_re = clamp_mag(up_data_i.re.neg, up_data_i.re.ovf ? '1 : div_re);
          p_im = clamp_mag(up_data_i.im.neg, up_data_i.im.ovf ? '1 : div_im);
          word_d.status = (p_re.sat || p_im.sat) ? ST_SAT : ST_OK;
        end
      end
      default: begin
        word_d.status = ST_INVALID;
      end
    endcase
    word_d.result_real = p_re.val;
    word_d.result_imag = p_im.val;
  end

  // output register
  assign up_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready_o && up_valid_i) word_q <= word_d;
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

// ===== src/complex_arith_unit.sv =====
// complex arithmetic unit
// in channel: in_valid_i / in_ready_o carry one word of operation code and
// two complex operands, each part signed Q16.16 (a real operand has its
// imaginary part at zero). codes: add, subtract, multiply, divide; any
// other code gives zero parts with status invalid operation.
// out channel: out_valid_o / out_ready_i carry the two result parts,
// saturated to 32 bits, and a status: ok, invalid, divide by zero (parts
// zero) or saturated.
// from accept to result valid a word passes three front stages (products,
// sums, quotient range check), one stage per quotient bit of the restoring
// divider (33 stages) and the output register. every op takes the same
// path, so results leave in input order. throughput is one word per cycle
// unless the receiver stalls; every stage holds a valid bit and takes a
// new word whenever it is empty or its successor moves on. when the
// receiver stalls, words pile up stage by stage and in_ready_o drops only
// once the pipeline is full. reset clears all valid bits.
module complex_arith_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cau_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cau_pkg::out_word_t out_word_o
);
  import cau_pkg::*;

  dvs_t chain_data  [QUO_W+1];
  logic chain_valid [QUO_W+1];
  logic chain_ready [QUO_W+1];

  // products, sums and range check
  cau_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .dn_valid_o (chain_valid[0]),
    .dn_ready_i (chain_ready[0]),
    .dn_data_o  (chain_data[0])
  );

  // divider, most significant quotient bit first
  for (genvar g = 0; g < QUO_W; g++) begin : g_div
    cau_div_step #(
      .BitPos (QUO_W - 1 - g)
    ) u_step (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .up_valid_i (chain_valid[g]),
      .up_ready_o (chain_ready[g]),
      .up_data_i  (chain_data[g]),
      .dn_valid_o (chain_valid[g+1]),
      .dn_ready_i (chain_ready[g+1]),
      .dn_data_o  (chain_data[g+1])
    );
  end

  // rounding, saturation and output register
  cau_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .up_valid_i  (chain_valid[QUO_W]),
    .up_ready_o  (chain_ready[QUO_W]),
    .up_data_i   (chain_data[QUO_W]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== src/cau_checker.sv =====
module cau_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input cau_pkg::in_word_t  in_word_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input cau_pkg::out_word_t out_word_o
);
  import cau_pkg::*;

  localparam logic signed [PART_W-1:0] PartMax = {1'b0, {(PART_W-1){1'b1}}};
  localparam logic signed [PART_W-1:0] PartMin = {1'b1, {(PART_W-1){1'b0}}};

  // a waiting input word stays until taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_word_i))
    else $error("input word dropped or changed while waiting");

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_word_o))
    else $error("result word changed while stalled");

  // error statuses give zero parts
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.status == ST_INVALID || out_word_o.status == ST_DIV_ZERO)
    |-> out_word_o.result_real == '0 && out_word_o.result_imag == '0)
    else $error("error status with nonzero result");

  // saturated status needs a part at a range limit
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status == ST_SAT
    |-> out_word_o.result_real == PartMax || out_word_o.result_real == PartMin
     || out_word_o.result_imag == PartMax || out_word_o.result_imag == PartMin)
    else $error("saturated status without a clamped part");

endmodule

bind complex_arith_unit cau_checker u_cau_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);

// ===== sim/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cau_pkg::*;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_word_t out_word_o;

  complex_arith_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_word_i(in_word_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_word_o(out_word_o)
  );

  localparam int LATENCY = 37;
  localparam logic signed [127:0] MAXV = (128'sd1 <<< (PART_W - 1)) - 1;
  localparam logic signed [127:0] MINV = -(128'sd1 <<< (PART_W - 1));

  in_word_t  pending_words[$];
  out_word_t expected_words[$];
  int        error_count;
  int        sent_count;
  int        recv_count;
  int        status_seen[4];
  bit        stim_done;
  bit        in_accepted;

  // clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // clamp an exact value to the part range
  function automatic logic signed [PART_W-1:0] saturate(logic signed [127:0] v, ref bit sat);
    if (v > MAXV) begin
      sat = 1'b1;
      return MAXV[PART_W-1:0];
    end
    if (v < MINV) begin
      sat = 1'b1;
      return MINV[PART_W-1:0];
    end
    return v[PART_W-1:0];
  endfunction

  // round a Q(2F) value to Q(F), ties away from zero
  function automatic logic signed [127:0] round_product(logic signed [127:0] v);
    logic [127:0] m;
    m = (v < 0) ? -v : v;
    m = (m + (128'd1 << (FRAC_W - 1))) >> FRAC_W;
    return (v < 0) ? -$signed(m) : $signed(m);
  endfunction

  // round(n * 2^F / d), ties away from zero
  function automatic logic signed [127:0] round_quotient(logic signed [127:0] n,
                                                          logic [127:0] d);
    logic [127:0] m;
    m = (n < 0) ? -n : n;
    m = (((m << (FRAC_W + 1)) / d) + 128'd1) >> 1;
    return (n < 0) ? -$signed(m) : $signed(m);
  endfunction

  // expected result of one complex operation
  function automatic out_word_t complex_result(in_word_t w);
    out_word_t r;
    bit sat;
    logic signed [127:0] ar, ai, br, bi, nre, nim;
    logic [127:0] den;
    sat = 1'b0;
    ar = w.a_real; ai = w.a_imag; br = w.b_real; bi = w.b_imag;
    r.result_real = '0;
    r.result_imag = '0;
    r.status = ST_OK;
    case (w.operation)
      OP_ADD: begin
        r.result_real = saturate(ar + br, sat);
        r.result_imag = saturate(ai + bi, sat);
      end
      OP_SUB: begin
        r.result_real = saturate(ar - br, sat);
        r.result_imag = saturate(ai - bi, sat);
      end
      OP_MUL: begin
        r.result_real = saturate(round_product(ar * br - ai * bi), sat);
        r.result_imag = saturate(round_product(ar * bi + ai * br), sat);
      end
      OP_DIV: begin
        if (br == 0 && bi == 0) begin
          r.status = ST_DIV_ZERO;
        end else begin
          den = br * br + bi * bi;
          nre = ar * br + ai * bi;
          nim = ai * br - ar * bi;
          r.result_real = saturate(round_quotient(nre, den), sat);
          r.result_imag = saturate(round_quotient(nim, den), sat);
        end
      end
      default: r.status = ST_INVALID;
    endcase
    if (r.status == ST_OK && sat) r.status = ST_SAT;
    return r;
  endfunction

  function automatic int gap_length();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  function automatic logic [PART_W-1:0] rand_part();
    int p;
    p = $urandom_range(0, 9);
    case (p)
      0: return {1'b0, {(PART_W-1){1'b1}}};
      1: return {1'b1, {(PART_W-1){1'b0}}};
      2: return '0;
      3, 4: return $signed($urandom_range(0, 8'hff)) - 128;
      5, 6: return {{(PART_W-20){$urandom_range(0,1) == 1}}, 20'($urandom())};
      default: return $urandom();
    endcase
  endfunction

  task automatic add_word(logic [2:0] op, logic [PART_W-1:0] ar, logic [PART_W-1:0] ai,
                          logic [PART_W-1:0] br, logic [PART_W-1:0] bi);
    in_word_t w;
    w.operation = op;
    w.a_real = ar; w.a_imag = ai; w.b_real = br; w.b_imag = bi;
    pending_words.push_back(w);
  endtask

  task automatic report_mismatch(string what, int idx, longint got, longint want);
    $display("mismatch word %0d %s: got %0h want %0h", idx, what, got, want);
    error_count++;
  endtask

  // stimulus
  initial begin
    logic [PART_W-1:0] mx, mn, one;
    logic [2:0] op;
    mx = {1'b0, {(PART_W-1){1'b1}}};
    mn = {1'b1, {(PART_W-1){1'b0}}};
    one = 1 << FRAC_W;
    stim_done = 1'b0;
    add_word(OP_ADD, one, one, one, -one);
    add_word(OP_ADD, mx, mn, mx, mn);
    add_word(OP_SUB, mn, mx, mx, mn);
    add_word(OP_SUB, 5, -5, 7, 3);
    add_word(OP_MUL, one, one, one, -one);
    add_word(OP_MUL, mx, mx, mx, mn);
    add_word(OP_MUL, mn, mn, mn, mn);
    add_word(OP_MUL, 1, 0, 32'h8000, 0);
    add_word(OP_MUL, -1, 0, 32'h8000, 0);
    add_word(OP_DIV, one, 0, 0, 0);
    add_word(OP_DIV, mx, mn, 0, 0);
    add_word(OP_DIV, one, one, one, one);
    add_word(OP_DIV, mx, mx, 1, 0);
    add_word(OP_DIV, mn, mn, mn, mn);
    add_word(OP_DIV, 1, 0, 3 * one, 0);
    add_word(OP_DIV, one, 0, 2 * one, 0);
    add_word(OP_DIV, mn, 0, -1, 0);
    add_word(OP_REM, one, one, one, one);
    add_word(3'd5, mx, mx, mx, mx);
    add_word(3'd6, 0, 0, 0, 0);
    add_word(3'd7, mn, mn, mn, mn);
    for (int i = 0; i < 1650; i++) begin
      op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3));
      add_word(op, rand_part(), rand_part(), rand_part(),
               ($urandom_range(0, 9) == 0) ? '0 : rand_part());
    end
    wait (pending_words.size() == 0 && !in_valid_i);
    stim_done = 1'b1;
  end

  // input handshake as seen at the rising edge
  always @(posedge clk_i) begin
    in_accepted <= rst_ni && in_valid_i && in_ready_o;
  end

  // driver
  int in_gap;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_word_i <= '0;
      in_gap = 0;
    end else if (!in_valid_i || in_accepted) begin
      if (in_valid_i) in_gap = gap_length();
      if (in_gap > 0 || pending_words.size() == 0) begin
        if (in_gap > 0) in_gap--;
        in_valid_i <= 1'b0;
      end else begin
        in_word_i <= pending_words[0];
        expected_words.push_back(complex_result(pending_words[0]));
        void'(pending_words.pop_front());
        in_valid_i <= 1'b1;
        sent_count++;
      end
    end
  end

  // receiver stalls
  int out_gap;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_gap = 0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready_i <= 1'b0;
    end else begin
      out_gap = gap_length();
      out_ready_i <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_words.size() == 0) begin
        $display("unexpected result word %0d", recv_count);
        error_count++;
      end else begin
        want = expected_words.pop_front();
        if (out_word_o.result_real !== want.result_real)
          report_mismatch("result_real", recv_count, out_word_o.result_real,
                          want.result_real);
        if (out_word_o.result_imag !== want.result_imag)
          report_mismatch("result_imag", recv_count, out_word_o.result_imag,
                          want.result_imag);
        if (out_word_o.status !== want.status)
          report_mismatch("status", recv_count, out_word_o.status, want.status);
        status_seen[want.status]++;
      end
      recv_count++;
    end
  end

  // reset and end of run
  initial begin
    error_count = 0;
    sent_count = 0;
    recv_count = 0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (stim_done && expected_words.size() == 0);
    repeat (LATENCY * 3) @(posedge clk_i);
    $display("sent %0d words, received %0d", sent_count, recv_count);
    $display("status ok %0d, invalid %0d, divide by zero %0d, saturated %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (error_count == 0) begin
      $display("** complex_arith_unit: PASSED **");
    end else begin
      $display("** complex_arith_unit: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("timeout");
    $display("** complex_arith_unit: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
src/cau_pkg.sv
src/cau_front.sv
src/cau_div_step.sv
src/cau_back.sv
src/complex_arith_unit.sv
src/cau_checker.sv
sim/tb_top.sv
